FILE: rtl/core/dps_pkg.sv
package dps_pkg;

    // Command codes
    localparam logic [1:0] CMD_OFFER  = 2'd0;
    localparam logic [1:0] CMD_TICK   = 2'd1;
    localparam logic [1:0] CMD_LINK   = 2'd2;

    // Packet kinds
    localparam logic [2:0] KIND_LOG     = 3'd0;
    localparam logic [2:0] KIND_TELEM   = 3'd1;
    localparam logic [2:0] KIND_REPORT  = 3'd2;
    localparam logic [2:0] KIND_PICTURE = 3'd3;

    // Offer status codes
    localparam logic [2:0] ST_STORED     = 3'd0;
    localparam logic [2:0] ST_FULL       = 3'd1;
    localparam logic [2:0] ST_TOO_BIG    = 3'd2;
    localparam logic [2:0] ST_BAD_REPORT = 3'd3;
    localparam logic [2:0] ST_IGNORED    = 3'd4;
    localparam logic [2:0] ST_NOT_OFFER  = 3'd5;

    // Grant sources
    localparam logic [2:0] SRC_NONE    = 3'd0;
    localparam logic [2:0] SRC_LOG     = 3'd1;
    localparam logic [2:0] SRC_TELEM   = 3'd2;
    localparam logic [2:0] SRC_PICTURE = 3'd3;
    localparam logic [2:0] SRC_REPORT  = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] REG_FORCE_INTERVAL = 2'd0;
    localparam logic [1:0] REG_REPORT_SIZE    = 2'd1;
    localparam logic [1:0] REG_PICTURE_MAX    = 2'd2;

    // Configuration reset values
    localparam logic [15:0] FORCE_INTERVAL_RST = 16'd20;
    localparam logic [7:0]  REPORT_SIZE_RST    = 8'd64;
    localparam logic [7:0]  PICTURE_MAX_RST    = 8'd250;

    typedef struct packed {
        logic       put;
        logic       get;
        logic [7:0] size;
    } t_ring_ctl;

    typedef struct packed {
        logic       full;
        logic       empty;
        logic [2:0] wr_slot;
        logic [2:0] rd_slot;
        logic [7:0] head_size;
    } t_ring_stat;

endpackage

FILE: rtl/core/dps_ram.sv
module dps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/core/dps_ring.sv
module dps_ring #(
    parameter int SLOTS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  dps_pkg::t_ring_ctl    i_ctl,
    output dps_pkg::t_ring_stat   o_stat
);

    localparam int IW = $clog2(SLOTS);
    localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

    logic [IW-1:0] r_wr;
    logic [IW-1:0] r_rd;
    logic [IW-1:0] n_wr;
    logic [IW-1:0] n_rd;
    logic [IW-1:0] wr_inc;
    logic [IW-1:0] rd_inc;
    logic          full;
    logic          empty;
    logic          wr_en;
    logic          r_byp_hit;
    logic [7:0]    r_byp_data;
    logic [7:0]    ram_q;
    logic [IW+2:0] wr_ext;
    logic [IW+2:0] rd_ext;

    assign wr_inc = (r_wr == LAST) ? '0 : r_wr + 1'b1;
    assign rd_inc = (r_rd == LAST) ? '0 : r_rd + 1'b1;
    assign full   = (wr_inc == r_rd);
    assign empty  = (r_wr == r_rd);
    assign wr_en  = i_ctl.put && !full;
    assign n_wr   = wr_en ? wr_inc : r_wr;
    assign n_rd   = (i_ctl.get && !empty) ? rd_inc : r_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr      <= '0;
            r_rd      <= '0;
            r_byp_hit <= 1'b0;
        end else begin
            r_wr      <= n_wr;
            r_rd      <= n_rd;
            r_byp_hit <= wr_en && (r_wr == n_rd);
        end
        r_byp_data <= i_ctl.size;
    end

    // Read the next head every cycle; forward a write landing on it
    dps_ram #(
        .WIDTH (8),
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_wr),
        .i_wr_data (i_ctl.size),
        .i_rd_addr (n_rd),
        .o_rd_data (ram_q)
    );

    assign wr_ext = {3'b000, r_wr};
    assign rd_ext = {3'b000, r_rd};

    assign o_stat.full      = full;
    assign o_stat.empty     = empty;
    assign o_stat.wr_slot   = wr_ext[2:0];
    assign o_stat.rd_slot   = rd_ext[2:0];
    assign o_stat.head_size = r_byp_hit ? r_byp_data : ram_q;

endmodule

FILE: rtl/core/downlink_priority_scheduler_top.sv
// Downlink priority scheduler: keeps size descriptors for log and telemetry
// packets in two rings (each holds SLOTS-1 items) and single overwrite slots
// for report and picture packets. Offer items return a status and the slot
// to write the payload into; tick items grant at most one packet while the
// link is free, in order overdue report, log, telemetry, picture, report.
// The decision for each item is made in the accept cycle and lands in the
// output register, so with no downstream stall one item is taken every
// clock. The ring head size comes from a registered-read RAM that is
// pre-read at the next head address. Configuration writes are always
// ready and take effect on the following item.
module downlink_priority_scheduler_top #(
    parameter int LOG_SLOTS        = 8,
    parameter int TELEM_SLOTS      = 8,
    parameter int MAX_PACKET_BYTES = 250
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_cmd,
    input  logic [2:0]  i_packet_kind,
    input  logic [9:0]  i_packet_size,
    input  logic [31:0] i_now_seconds,
    input  logic        i_link_free,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_offer_status,
    output logic [2:0]  o_store_slot,
    output logic [2:0]  o_grant_source,
    output logic [2:0]  o_grant_slot,
    output logic [7:0]  o_grant_size,
    output logic        o_grant_forced,
    output logic        o_ask_next_picture,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam logic [9:0] MAX_BYTES = 10'(MAX_PACKET_BYTES);

    logic [15:0] r_force_interval;
    logic [7:0]  r_report_size;
    logic [7:0]  r_picture_max;

    logic        r_picture_pending;
    logic [7:0]  r_picture_bytes;
    logic        r_report_pending;
    logic [31:0] r_last_report;
    logic        r_radio_free;

    logic        n_picture_pending;
    logic [7:0]  n_picture_bytes;
    logic        n_report_pending;
    logic [31:0] n_last_report;
    logic        n_radio_free;

    logic        r_out_valid;
    logic [2:0]  r_status;
    logic [2:0]  r_store_slot;
    logic [2:0]  r_source;
    logic [2:0]  r_grant_slot;
    logic [7:0]  r_grant_size;
    logic        r_forced;
    logic        r_ask;

    logic [2:0]  n_status;
    logic [2:0]  n_store_slot;
    logic [2:0]  n_source;
    logic [2:0]  n_grant_slot;
    logic [7:0]  n_grant_size;
    logic        n_forced;
    logic        n_ask;

    logic        accept;
    logic        overdue;
    logic [31:0] age;

    dps_pkg::t_ring_ctl  log_ctl;
    dps_pkg::t_ring_ctl  telem_ctl;
    dps_pkg::t_ring_stat log_stat;
    dps_pkg::t_ring_stat telem_stat;

    assign o_stall     = r_out_valid && i_stall;
    assign accept      = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    assign age     = i_now_seconds - r_last_report;
    assign overdue = r_report_pending && (age > {16'd0, r_force_interval});

    always_comb begin
        n_status          = dps_pkg::ST_NOT_OFFER;
        n_store_slot      = 3'd0;
        n_source          = dps_pkg::SRC_NONE;
        n_grant_slot      = 3'd0;
        n_grant_size      = 8'd0;
        n_forced          = 1'b0;
        n_ask             = 1'b0;
        n_picture_pending = r_picture_pending;
        n_picture_bytes   = r_picture_bytes;
        n_report_pending  = r_report_pending;
        n_last_report     = r_last_report;
        n_radio_free      = r_radio_free;
        log_ctl.put       = 1'b0;
        log_ctl.get       = 1'b0;
        log_ctl.size      = i_packet_size[7:0];
        telem_ctl.put     = 1'b0;
        telem_ctl.get     = 1'b0;
        telem_ctl.size    = i_packet_size[7:0];

        case (i_cmd)
            dps_pkg::CMD_OFFER: begin
                if (i_packet_size > MAX_BYTES) begin
                    n_status = dps_pkg::ST_TOO_BIG;
                end else begin
                    case (i_packet_kind)
                        dps_pkg::KIND_LOG: begin
                            if (log_stat.full) begin
                                n_status = dps_pkg::ST_FULL;
                            end else begin
                                n_status     = dps_pkg::ST_STORED;
                                n_store_slot = log_stat.wr_slot;
                                log_ctl.put  = accept;
                            end
                        end
                        dps_pkg::KIND_TELEM: begin
                            if (telem_stat.full) begin
                                n_status = dps_pkg::ST_FULL;
                            end else begin
                                n_status      = dps_pkg::ST_STORED;
                                n_store_slot  = telem_stat.wr_slot;
                                telem_ctl.put = accept;
                            end
                        end
                        dps_pkg::KIND_REPORT: begin
                            if (i_packet_size == {2'b00, r_report_size}) begin
                                n_status         = dps_pkg::ST_STORED;
                                n_report_pending = 1'b1;
                            end else begin
                                n_status = dps_pkg::ST_BAD_REPORT;
                            end
                        end
                        dps_pkg::KIND_PICTURE: begin
                            if (i_packet_size <= {2'b00, r_picture_max}) begin
                                n_status          = dps_pkg::ST_STORED;
                                n_picture_pending = 1'b1;
                                n_picture_bytes   = i_packet_size[7:0];
                            end else begin
                                n_status = dps_pkg::ST_TOO_BIG;
                            end
                        end
                        default: begin
                            n_status = dps_pkg::ST_IGNORED;
                        end
                    endcase
                end
            end
            dps_pkg::CMD_TICK: begin
                if (r_radio_free) begin
                    if (overdue) begin
                        n_source         = dps_pkg::SRC_REPORT;
                        n_grant_size     = r_report_size;
                        n_forced         = 1'b1;
                        n_report_pending = 1'b0;
                        n_last_report    = i_now_seconds;
                    end else if (!log_stat.empty) begin
                        n_source     = dps_pkg::SRC_LOG;
                        n_grant_slot = log_stat.rd_slot;
                        n_grant_size = log_stat.head_size;
                        log_ctl.get  = accept;
                    end else if (!telem_stat.empty) begin
                        n_source      = dps_pkg::SRC_TELEM;
                        n_grant_slot  = telem_stat.rd_slot;
                        n_grant_size  = telem_stat.head_size;
                        telem_ctl.get = accept;
                    end else if (r_picture_pending) begin
                        n_source          = dps_pkg::SRC_PICTURE;
                        n_grant_size      = r_picture_bytes;
                        n_ask             = 1'b1;
                        n_picture_pending = 1'b0;
                    end else if (r_report_pending) begin
                        n_source         = dps_pkg::SRC_REPORT;
                        n_grant_size     = r_report_size;
                        n_report_pending = 1'b0;
                        n_last_report    = i_now_seconds;
                    end
                end
            end
            dps_pkg::CMD_LINK: begin
                n_radio_free = i_link_free;
            end
            default: begin
                n_status = dps_pkg::ST_NOT_OFFER;
            end
        endcase
    end

    dps_ring #(
        .SLOTS (LOG_SLOTS)
    ) u_log_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (log_ctl),
        .o_stat  (log_stat)
    );

    dps_ring #(
        .SLOTS (TELEM_SLOTS)
    ) u_telem_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (telem_ctl),
        .o_stat  (telem_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_force_interval  <= dps_pkg::FORCE_INTERVAL_RST;
            r_report_size     <= dps_pkg::REPORT_SIZE_RST;
            r_picture_max     <= dps_pkg::PICTURE_MAX_RST;
            r_picture_pending <= 1'b0;
            r_picture_bytes   <= 8'd0;
            r_report_pending  <= 1'b0;
            r_last_report     <= 32'd0;
            r_radio_free      <= 1'b1;
            r_out_valid       <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    dps_pkg::REG_FORCE_INTERVAL: r_force_interval <= i_cfg_data;
                    dps_pkg::REG_REPORT_SIZE:    r_report_size    <= i_cfg_data[7:0];
                    dps_pkg::REG_PICTURE_MAX:    r_picture_max    <= i_cfg_data[7:0];
                    default: begin
                        // drop writes beyond the register list
                    end
                endcase
            end
            if (accept) begin
                r_picture_pending <= n_picture_pending;
                r_picture_bytes   <= n_picture_bytes;
                r_report_pending  <= n_report_pending;
                r_last_report     <= n_last_report;
                r_radio_free      <= n_radio_free;
                r_out_valid       <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status     <= n_status;
            r_store_slot <= n_store_slot;
            r_source     <= n_source;
            r_grant_slot <= n_grant_slot;
            r_grant_size <= n_grant_size;
            r_forced     <= n_forced;
            r_ask        <= n_ask;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_offer_status     = r_status;
    assign o_store_slot       = r_store_slot;
    assign o_grant_source     = r_source;
    assign o_grant_slot       = r_grant_slot;
    assign o_grant_size       = r_grant_size;
    assign o_grant_forced     = r_forced;
    assign o_ask_next_picture = r_ask;

`ifndef SYNTH
    a_forced_is_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_grant_forced |-> o_grant_source == dps_pkg::SRC_REPORT)
        else $error("forced grant from a source other than report");

    a_grant_not_offer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_grant_source != dps_pkg::SRC_NONE)
        |-> o_offer_status == dps_pkg::ST_NOT_OFFER)
        else $error("grant reported on an offer item");

    a_report_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_cmd == dps_pkg::CMD_TICK) && (n_source == dps_pkg::SRC_REPORT)
        |=> !r_report_pending && (r_last_report == $past(i_now_seconds)))
        else $error("granted report still pending");

    a_ring_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(log_stat.full && log_stat.empty) && !(telem_stat.full && telem_stat.empty))
        else $error("ring both full and empty");
`endif

endmodule

FILE: tb/downlink_priority_scheduler_top_tb.sv
module downlink_priority_scheduler_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CMD_NOP       = 2'd3;
    localparam logic [2:0] KIND_IGNORED  = 3'd4;
    localparam logic [2:0] KIND_TOP      = 3'd7;
    localparam int         PKT_MAX_BYTES = 250;
    localparam int         HOLD_CYCLES   = 400;
    localparam int         PHASE_ITEMS   = 400;

    typedef struct {
        logic [1:0]  cmd;
        logic [2:0]  kind;
        logic [9:0]  size;
        logic [31:0] stamp;
        logic        link;
    } t_dl_item;

    typedef struct {
        logic [2:0] status;
        logic [2:0] store_slot;
        logic [2:0] source;
        logic [2:0] grant_slot;
        logic [7:0] grant_size;
        logic       forced;
        logic       ask_picture;
    } t_dl_decision;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_cmd = '0;
    logic [2:0]  i_packet_kind = '0;
    logic [9:0]  i_packet_size = '0;
    logic [31:0] i_now_seconds = '0;
    logic        i_link_free = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [2:0]  o_offer_status;
    logic [2:0]  o_store_slot;
    logic [2:0]  o_grant_source;
    logic [2:0]  o_grant_slot;
    logic [7:0]  o_grant_size;
    logic        o_grant_forced;
    logic        o_ask_next_picture;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    downlink_priority_scheduler_top uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_cmd              (i_cmd),
        .i_packet_kind      (i_packet_kind),
        .i_packet_size      (i_packet_size),
        .i_now_seconds      (i_now_seconds),
        .i_link_free        (i_link_free),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_offer_status     (o_offer_status),
        .o_store_slot       (o_store_slot),
        .o_grant_source     (o_grant_source),
        .o_grant_slot       (o_grant_slot),
        .o_grant_size       (o_grant_size),
        .o_grant_forced     (o_grant_forced),
        .o_ask_next_picture (o_ask_next_picture),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // Scheduler state as seen by the testbench
    logic [15:0] cfg_force_interval = dps_pkg::FORCE_INTERVAL_RST;
    logic [7:0]  cfg_report_size    = dps_pkg::REPORT_SIZE_RST;
    logic [7:0]  cfg_picture_max    = dps_pkg::PICTURE_MAX_RST;
    logic [2:0]  log_wr = '0;
    logic [2:0]  log_rd = '0;
    logic [7:0]  log_len [8];
    logic [2:0]  telem_wr = '0;
    logic [2:0]  telem_rd = '0;
    logic [7:0]  telem_len [8];
    logic        picture_waiting = 1'b0;
    logic [7:0]  picture_len = '0;
    logic        report_waiting = 1'b0;
    logic [31:0] last_report_stamp = '0;
    logic        link_up = 1'b1;

    t_dl_item     item_backlog [$];
    t_dl_decision decision_q [$];
    t_dl_item     cur_item;
    int           mismatches = 0;
    int           tx_gap_pct = 0;
    int           rx_stall_pct = 0;
    logic         hold_req = 1'b0;
    int           hold_left = 0;
    logic [31:0]  sim_seconds = '0;

    function automatic t_dl_decision decide_item(t_dl_item it);
        t_dl_decision d;
        logic [31:0]  age;
        d.status      = dps_pkg::ST_NOT_OFFER;
        d.store_slot  = '0;
        d.source      = dps_pkg::SRC_NONE;
        d.grant_slot  = '0;
        d.grant_size  = '0;
        d.forced      = 1'b0;
        d.ask_picture = 1'b0;
        case (it.cmd)
            dps_pkg::CMD_OFFER: begin
                if (it.size > PKT_MAX_BYTES) begin
                    d.status = dps_pkg::ST_TOO_BIG;
                end else if (it.kind == dps_pkg::KIND_LOG) begin
                    if (3'(log_wr + 3'd1) == log_rd) begin
                        d.status = dps_pkg::ST_FULL;
                    end else begin
                        log_len[log_wr] = it.size[7:0];
                        d.store_slot = log_wr;
                        d.status = dps_pkg::ST_STORED;
                        log_wr = 3'(log_wr + 3'd1);
                    end
                end else if (it.kind == dps_pkg::KIND_TELEM) begin
                    if (3'(telem_wr + 3'd1) == telem_rd) begin
                        d.status = dps_pkg::ST_FULL;
                    end else begin
                        telem_len[telem_wr] = it.size[7:0];
                        d.store_slot = telem_wr;
                        d.status = dps_pkg::ST_STORED;
                        telem_wr = 3'(telem_wr + 3'd1);
                    end
                end else if (it.kind == dps_pkg::KIND_REPORT) begin
                    if (it.size == {2'b00, cfg_report_size}) begin
                        report_waiting = 1'b1;
                        d.status = dps_pkg::ST_STORED;
                    end else begin
                        d.status = dps_pkg::ST_BAD_REPORT;
                    end
                end else if (it.kind == dps_pkg::KIND_PICTURE) begin
                    if (it.size <= {2'b00, cfg_picture_max}) begin
                        picture_len = it.size[7:0];
                        picture_waiting = 1'b1;
                        d.status = dps_pkg::ST_STORED;
                    end else begin
                        d.status = dps_pkg::ST_TOO_BIG;
                    end
                end else begin
                    d.status = dps_pkg::ST_IGNORED;
                end
            end
            dps_pkg::CMD_TICK: begin
                if (link_up) begin
                    // age wraps modulo 2^32
                    age = it.stamp - last_report_stamp;
                    if (report_waiting && age > {16'd0, cfg_force_interval}) begin
                        d.source = dps_pkg::SRC_REPORT;
                        d.grant_size = cfg_report_size;
                        d.forced = 1'b1;
                        report_waiting = 1'b0;
                        last_report_stamp = it.stamp;
                    end else if (log_rd != log_wr) begin
                        d.source = dps_pkg::SRC_LOG;
                        d.grant_slot = log_rd;
                        d.grant_size = log_len[log_rd];
                        log_rd = 3'(log_rd + 3'd1);
                    end else if (telem_rd != telem_wr) begin
                        d.source = dps_pkg::SRC_TELEM;
                        d.grant_slot = telem_rd;
                        d.grant_size = telem_len[telem_rd];
                        telem_rd = 3'(telem_rd + 3'd1);
                    end else if (picture_waiting) begin
                        d.source = dps_pkg::SRC_PICTURE;
                        d.grant_size = picture_len;
                        d.ask_picture = 1'b1;
                        picture_waiting = 1'b0;
                    end else if (report_waiting) begin
                        d.source = dps_pkg::SRC_REPORT;
                        d.grant_size = cfg_report_size;
                        report_waiting = 1'b0;
                        last_report_stamp = it.stamp;
                    end
                end
            end
            dps_pkg::CMD_LINK: link_up = it.link;
            default: ;
        endcase
        return d;
    endfunction

    task automatic flag_mismatch(input string msg);
        if (mismatches < 40) begin
            $display("mismatch at %0t: %s", $time, msg);
        end
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            flag_mismatch($sformatf("%s got %0d, want %0d", name, got, want));
        end
    endtask

    // Sender: advance to the next item once the current one is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                decision_q.push_back(decide_item(cur_item));
            end
            if (!i_valid || !o_stall) begin
                if (item_backlog.size() != 0 && $urandom_range(99) >= tx_gap_pct) begin
                    cur_item = item_backlog.pop_front();
                    i_cmd         <= cur_item.cmd;
                    i_packet_kind <= cur_item.kind;
                    i_packet_size <= cur_item.size;
                    i_now_seconds <= cur_item.stamp;
                    i_link_free   <= cur_item.link;
                    i_valid       <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : result_monitor
        t_dl_decision want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (decision_q.size() == 0) begin
                    flag_mismatch("result with nothing outstanding");
                end else begin
                    want = decision_q.pop_front();
                    check_field("offer_status", 32'(o_offer_status), 32'(want.status));
                    check_field("store_slot", 32'(o_store_slot), 32'(want.store_slot));
                    check_field("grant_source", 32'(o_grant_source), 32'(want.source));
                    check_field("grant_slot", 32'(o_grant_slot), 32'(want.grant_slot));
                    check_field("grant_size", 32'(o_grant_size), 32'(want.grant_size));
                    check_field("grant_forced", 32'(o_grant_forced), 32'(want.forced));
                    check_field("ask_next_picture", 32'(o_ask_next_picture),
                                32'(want.ask_picture));
                end
            end
            i_stall <= (hold_left != 0) || ($urandom_range(99) < rx_stall_pct);
        end
    end

    // Long receiver hold-off, counted here
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    task automatic push_item(input logic [1:0] cmd, input logic [2:0] kind,
                             input logic [9:0] size, input logic [31:0] stamp,
                             input logic link);
        t_dl_item it;
        it.cmd   = cmd;
        it.kind  = kind;
        it.size  = size;
        it.stamp = stamp;
        it.link  = link;
        item_backlog.push_back(it);
    endtask

    task automatic add_random_burst(input int count, input int offer_pct);
        logic [1:0]  cmd;
        logic [2:0]  kind;
        logic [9:0]  size;
        logic [31:0] stamp;
        logic        link;
        int          pick;
        for (int n = 0; n < count; n++) begin
            kind  = 3'($urandom_range(0, 7));
            size  = 10'($urandom);
            stamp = $urandom;
            link  = 1'($urandom);
            pick  = $urandom_range(99);
            if (pick < offer_pct) begin
                cmd = dps_pkg::CMD_OFFER;
                kind = ($urandom_range(99) < 6) ? 3'($urandom_range(4, 7))
                                                : 3'($urandom_range(0, 3));
                if ($urandom_range(99) < 8) begin
                    size = 10'($urandom_range(PKT_MAX_BYTES + 1, 1023));
                end else if (kind == dps_pkg::KIND_REPORT && $urandom_range(99) < 70) begin
                    size = {2'b00, cfg_report_size};
                end else if (kind == dps_pkg::KIND_PICTURE && $urandom_range(99) < 70) begin
                    size = 10'($urandom_range(0, cfg_picture_max));
                end else begin
                    size = 10'($urandom_range(0, PKT_MAX_BYTES));
                end
            end else if (pick < 92) begin
                cmd = dps_pkg::CMD_TICK;
                if ($urandom_range(99) < 5) begin
                    sim_seconds = $urandom;
                end else if ($urandom_range(99) < 5) begin
                    sim_seconds += $urandom_range(0, 200000);
                end else begin
                    sim_seconds += $urandom_range(0, 6);
                end
                stamp = sim_seconds;
            end else if (pick < 98) begin
                cmd = dps_pkg::CMD_LINK;
                link = ($urandom_range(99) < 75);
            end else begin
                cmd = CMD_NOP;
            end
            push_item(cmd, kind, size, stamp, link);
        end
    endtask

    task automatic add_random(input int total);
        int left;
        int n;
        left = total;
        while (left > 0) begin
            n = $urandom_range(20, 60);
            if (n > left) n = left;
            add_random_burst(n, $urandom_range(25, 75));
            left -= n;
        end
    endtask

    // Wait until every item is taken and every result has come back
    task automatic settle();
        while (item_backlog.size() != 0 || i_valid || decision_q.size() != 0 ||
               hold_left != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            dps_pkg::REG_FORCE_INTERVAL: cfg_force_interval = val;
            dps_pkg::REG_REPORT_SIZE:    cfg_report_size = val[7:0];
            dps_pkg::REG_PICTURE_MAX:    cfg_picture_max = val[7:0];
            default: ;
        endcase
    endtask

    task automatic configure(input int force_ivl, input int rpt_size, input int pic_max);
        write_reg(dps_pkg::REG_FORCE_INTERVAL, 16'(force_ivl));
        write_reg(dps_pkg::REG_REPORT_SIZE, 16'(rpt_size));
        write_reg(dps_pkg::REG_PICTURE_MAX, 16'(pic_max));
        @(posedge i_clk);
    endtask

    task automatic set_idling(input int tx_pct, input int rx_pct);
        tx_gap_pct   <= tx_pct;
        rx_stall_pct <= rx_pct;
        @(posedge i_clk);
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset configuration: force 20, report 64, picture max 250
        push_item(dps_pkg::CMD_OFFER, dps_pkg::KIND_LOG, 10'd0, 32'd0, 1'b0);
        push_item(dps_pkg::CMD_OFFER, dps_pkg::KIND_LOG, 10'd250, 32'hFFFF_FFFF, 1'b1);
        push_item(dps_pkg::CMD_OFFER, dps_pkg::KIND_TELEM, 10'd251, 32'd0, 1'b0);
        push_item(dps_pkg::CMD_OFFER, KIND_TOP, 10'd1023, 32'd0, 1'b1);
        push_item(dps_pkg::CMD_OFFER, KIND_IGNORED, 10'd5, 32'd0, 1'b0);
        push_item(dps_pkg::CMD_OFFER, dps_pkg::KIND_REPORT, 10'd63, 32'd0, 1'b0);
        push_item(dps_pkg::CMD_OFFER, dps_pkg::KIND_REPORT, 10'd64, 32'd0, 1'b0);
        push_item(dps_pkg::CMD_OFFER, dps_pkg::KIND_PICTURE, 10'd250, 32'd0, 1'b0);
        push_item(CMD_NOP, 3'd5, 10'd600, 32'hA5A5_5A5A, 1'b1);
        // busy link: tick grants nothing
        push_item(dps_pkg::CMD_LINK, dps_pkg::KIND_LOG, 10'd0, 32'd0, 1'b0);
        push_item(dps_pkg::CMD_TICK, dps_pkg::KIND_LOG, 10'd0, 32'd100, 1'b1);
        push_item(dps_pkg::CMD_LINK, dps_pkg::KIND_LOG, 10'd0, 32'd0, 1'b1);
        // overdue report first, then log, log, picture
        push_item(dps_pkg::CMD_TICK, dps_pkg::KIND_LOG, 10'd0, 32'd30, 1'b0);
        push_item(dps_pkg::CMD_TICK, dps_pkg::KIND_LOG, 10'd0, 32'd31, 1'b0);
        push_item(dps_pkg::CMD_TICK, dps_pkg::KIND_LOG, 10'd0, 32'd32, 1'b0);
        push_item(dps_pkg::CMD_TICK, dps_pkg::KIND_LOG, 10'd0, 32'd33, 1'b0);
        // time going back wraps the age and forces the report
        push_item(dps_pkg::CMD_OFFER, dps_pkg::KIND_REPORT, 10'd64, 32'd0, 1'b0);
        push_item(dps_pkg::CMD_TICK, dps_pkg::KIND_LOG, 10'd0, 32'd29, 1'b0);
        push_item(dps_pkg::CMD_OFFER, dps_pkg::KIND_REPORT, 10'd64, 32'd0, 1'b0);
        push_item(dps_pkg::CMD_TICK, dps_pkg::KIND_LOG, 10'd0, 32'd30, 1'b0);
        push_item(dps_pkg::CMD_TICK, dps_pkg::KIND_LOG, 10'd0, 32'd31, 1'b0);
        // fill the log ring until it refuses
        for (int n = 1; n <= 8; n++) begin
            push_item(dps_pkg::CMD_OFFER, dps_pkg::KIND_LOG, 10'(n), 32'd0, 1'b0);
        end
        sim_seconds = 32'd31;
        settle();

        configure(0, 0, 0);
        add_random(PHASE_ITEMS);
        settle();

        configure(65535, 250, 250);
        set_idling(76, 0);
        add_random(PHASE_ITEMS);
        settle();

        configure($urandom_range(0, 65535), $urandom_range(0, 250), $urandom_range(0, 250));
        set_idling(0, 76);
        add_random(PHASE_ITEMS);
        settle();

        configure($urandom_range(0, 40), $urandom_range(0, 250), $urandom_range(100, 250));
        set_idling(20, 20);
        add_random(PHASE_ITEMS);
        settle();

        // hold the output side while the sender keeps pushing
        configure(15, 100, 180);
        set_idling(0, 0);
        hold_req <= 1'b1;
        @(posedge i_clk);
        hold_req <= 1'b0;
        add_random(PHASE_ITEMS);
        settle();

        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/dps_pkg.sv
rtl/core/dps_ram.sv
rtl/core/dps_ring.sv
rtl/core/downlink_priority_scheduler_top.sv
tb/downlink_priority_scheduler_top_tb.sv
